// ===== rtl/lpkv_pkg.sv =====
// ============================================================================
// lpkv_pkg
// Shared types, constants and helpers of the linear-probe key/value table.
// ============================================================================
package lpkv_pkg;

    localparam int          LPKV_CAPACITY = 1024;
    localparam int          VALUE_BYTES   = 8;
    localparam int          QUEUE_DEPTH   = 2;
    localparam logic [31:0] HASH_MUL      = 32'h045d_9f3b;

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_GET = 2'd1,
        OP_ADD = 2'd2,
        OP_BAD = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_REJ  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    // One classified transaction on its way from the front to the back
    typedef struct packed {
        t_op         op;
        logic        reject;
        logic [31:0] key;
        logic [63:0] wval;
        logic [3:0]  cnt;
        logic [31:0] hash;
    } t_job;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // One round of the multiply-xor mix
    function automatic logic [31:0] mix_round(input logic [31:0] h);
        logic [31:0] x;
        x = h ^ (h >> 16);
        return x * HASH_MUL;
    endfunction

    // Mask of the low n bytes of a 64-bit word, all ones from 8 up
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (n > 4'(i)) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/lpkv_fifo.sv =====
// ============================================================================
// lpkv_fifo
// Short queue of classified jobs between the front and the back.
// ============================================================================
module lpkv_fifo
    import lpkv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_wdata,
    input  logic   i_pop,
    output t_job   o_rdata,
    output t_qstat o_stat
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_wdata;
    end

    assign o_rdata      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== rtl/lpkv_front.sv =====
// ============================================================================
// lpkv_front
// Accepts transactions, checks them for rejection and hashes the key.
// ============================================================================
module lpkv_front
    import lpkv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_key,
    input  logic [63:0] i_write_value,
    input  logic [3:0]  i_byte_count,
    input  logic        i_clearing,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_job        o_job
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MIX1 = 4'b0010,
        F_MIX2 = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;
    t_job    r_job;
    logic    accept;

    assign o_stall = (r_state != F_IDLE) || i_clearing;
    assign accept  = i_valid && !o_stall;
    assign o_push  = (r_state == F_PUSH) && !i_qstat.full;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (accept) n_state = F_MIX1;
            F_MIX1:  n_state = F_MIX2;
            F_MIX2:  n_state = F_PUSH;
            F_PUSH:  if (!i_qstat.full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture and classify, then two mix rounds; the final fold is combinational below
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    r_job.op     <= t_op'(i_opcode);
                    r_job.key    <= i_key;
                    r_job.wval   <= i_write_value;
                    r_job.cnt    <= i_byte_count;
                    r_job.hash   <= i_key;
                    r_job.reject <= (i_key == '0) || (t_op'(i_opcode) == OP_BAD) ||
                                    ((t_op'(i_opcode) == OP_SET) &&
                                     (i_byte_count > 4'(VALUE_BYTES)));
                end
            end
            F_MIX1:  r_job.hash <= mix_round(r_job.hash);
            F_MIX2:  r_job.hash <= mix_round(r_job.hash);
            F_PUSH:  ;
            default: ;
        endcase
    end

    always_comb begin
        o_job      = r_job;
        o_job.hash = r_job.hash ^ (r_job.hash >> 16);
    end

endmodule

// ===== rtl/lpkv_back.sv =====
// ============================================================================
// lpkv_back
// Slot memory, probe sequencer, counters and the result register.
// ============================================================================
module lpkv_back
    import lpkv_pkg::*;
#(
    parameter int CAPACITY = LPKV_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qstat      i_qstat,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_clearing,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_read_value,
    output logic [3:0]  o_read_length,
    output logic [10:0] o_entry_count,
    output logic [63:0] o_read_count,
    output logic [63:0] o_write_count,
    output logic [63:0] o_collision_count
);

    localparam int IW    = $clog2(CAPACITY);
    localparam int LIMIT = CAPACITY / 4;
    localparam int DW    = $clog2(LIMIT);
    localparam int EW    = 32 + 64 + 4;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_ADDR  = 4'b0100,
        B_EVAL  = 4'b1000
    } t_bstate;

    t_bstate       r_state, n_state;
    t_job          r_job;
    logic [IW-1:0] r_idx, r_clr;
    logic [DW-1:0] r_d;
    logic [EW-1:0] r_mem [CAPACITY];
    logic [EW-1:0] r_rd;
    logic [EW-1:0] wdata;
    logic [IW-1:0] waddr;
    logic          we;

    logic [10:0]   r_occ;
    logic [63:0]   r_reads, r_writes, r_misses;
    logic          r_ovalid;
    t_status       r_status;
    logic [63:0]   r_rval;
    logic [3:0]    r_rlen;

    // slot fields as read
    logic [31:0]   s_key;
    logic [63:0]   s_val;
    logic [3:0]    s_len;
    assign {s_key, s_val, s_len} = r_rd;

    // evaluation of one probed slot
    logic          done, last, ins, wr_hit;
    logic [63:0]   m_set, m_get, new_val;
    t_status       ev_status;
    logic [63:0]   ev_rval;
    logic [3:0]    ev_rlen;

    assign m_set = byte_mask(r_job.cnt);
    assign m_get = byte_mask(s_len);
    assign last  = (r_d == DW'(LIMIT - 1));

    always_comb begin
        done      = 1'b0;
        ins       = 1'b0;
        wr_hit    = 1'b0;
        new_val   = s_val;
        ev_status = ST_OK;
        ev_rval   = '0;
        ev_rlen   = '0;
        case (r_job.op)
            OP_SET: begin
                if (s_key == '0 || s_key == r_job.key) begin
                    done    = 1'b1;
                    wr_hit  = 1'b1;
                    ins     = (s_key == '0);
                    new_val = (s_val & ~m_set) | (r_job.wval & m_set);
                end else if (last) begin
                    ev_status = ST_FULL;
                end
            end
            OP_GET: begin
                if (s_key == r_job.key && r_job.cnt >= s_len) begin
                    done    = 1'b1;
                    ev_rval = s_val & m_get;
                    ev_rlen = s_len;
                end else if (s_key == '0 || last) begin
                    ev_status = ST_MISS;
                end
            end
            default: begin
                if (s_key == r_job.key) begin
                    done    = 1'b1;
                    wr_hit  = 1'b1;
                    new_val = s_val + r_job.wval;
                    ev_rval = s_val;
                end else if (s_key == '0) begin
                    done    = 1'b1;
                    wr_hit  = 1'b1;
                    ins     = 1'b1;
                    new_val = r_job.wval;
                end else if (last) begin
                    ev_status = ST_FULL;
                end
            end
        endcase
    end

    logic finish;
    assign finish = (r_state == B_EVAL) && (done || last ||
                    (r_job.op == OP_GET && s_key == '0 && !done));

    assign o_pop      = (r_state == B_IDLE) && !i_qstat.empty && !r_ovalid;
    assign o_clearing = (r_state == B_CLEAR);

    // memory write port: clearing pass or slot update
    // a fetch-add hit keeps the stored length, a fetch-add insert takes the full width, a set stores its count
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = '0;
        if (r_state == B_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
        end else if (r_state == B_EVAL && wr_hit) begin
            we    = 1'b1;
            wdata = {r_job.key, new_val,
                     (r_job.op == OP_SET) ? r_job.cnt :
                     (ins ? 4'(VALUE_BYTES) : s_len)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd <= r_mem[r_idx];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: if (r_clr == IW'(CAPACITY - 1)) n_state = B_IDLE;
            B_IDLE:  if (o_pop && !i_job.reject) n_state = B_ADDR;
            B_ADDR:  n_state = B_EVAL;
            B_EVAL:  n_state = finish ? B_IDLE : B_ADDR;
            default: n_state = B_IDLE;
        endcase
    end

    // control, counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_occ    <= '0;
            r_reads  <= '0;
            r_writes <= '0;
            r_misses <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (o_pop && i_job.reject) r_ovalid <= 1'b1;
            if (finish) begin
                r_ovalid <= 1'b1;
                if (ins) r_occ <= r_occ + 1'b1;
                if (r_job.op == OP_SET) begin
                    if (done) r_writes <= r_writes + 1'b1;
                    else      r_misses <= r_misses + 1'b1;
                end
                if (r_job.op == OP_GET && done) r_reads <= r_reads + 1'b1;
            end
        end
    end

    // job, probe position and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= i_job.hash[IW-1:0];
            r_d   <= '0;
            if (i_job.reject) begin
                r_status <= ST_REJ;
                r_rval   <= '0;
                r_rlen   <= '0;
            end
        end else if (r_state == B_EVAL) begin
            r_idx <= r_idx + 1'b1;
            r_d   <= r_d + 1'b1;
            if (finish) begin
                r_status <= ev_status;
                r_rval   <= ev_rval;
                r_rlen   <= ev_rlen;
            end
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_status;
    assign o_read_value      = r_rval;
    assign o_read_length     = r_rlen;
    assign o_entry_count     = r_occ;
    assign o_read_count      = r_reads;
    assign o_write_count     = r_writes;
    assign o_collision_count = r_misses;

`ifndef NO_ASSERTIONS
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_pop) else $error("job taken during clear");
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_occ == $past(r_occ) || r_occ == $past(r_occ) + 11'd1))
        else $error("entry count jumped");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> !r_ovalid) else $error("result overwritten");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EVAL && last) |=> (r_state == B_IDLE))
        else $error("probe ran past its limit");
`endif

endmodule

// ===== rtl/linear_probe_kv_table.sv =====
// ============================================================================
// linear_probe_kv_table
// Open-addressing key/value table with linear probing: set, get, fetch-add.
// ============================================================================
// After reset the block runs a clearing pass over every slot of the slot memory
// and takes no transaction until it is done. The front hashes each key with two
// mix rounds and a final fold and hands the job to a two-entry queue; the back
// then probes the slot memory with a registered read followed by an evaluate
// and write for each visited slot, at most CAPACITY/4 slots per probe. The
// front takes a new transaction once it has pushed the last one, while the back
// may still be probing.
// Rejected transactions are answered without a probe. The result is held in an
// output register; the next job leaves the queue once that result is taken.
// CAPACITY must be a power of two.
module linear_probe_kv_table
    import lpkv_pkg::*;
#(
    parameter int CAPACITY = LPKV_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_key,
    input  logic [63:0]        i_write_value,
    input  logic [3:0]         i_byte_count,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [63:0]        o_read_value,
    output logic [3:0]         o_read_length,
    output logic [10:0]        o_entry_count,
    output logic [63:0]        o_read_count,
    output logic [63:0]        o_write_count,
    output logic [63:0]        o_collision_count
);

    t_job   push_job, pop_job;
    t_qstat qstat;
    logic   push, pop, clearing;

    lpkv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .i_byte_count  (i_byte_count),
        .i_clearing    (clearing),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_job         (push_job)
    );

    lpkv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_job),
        .i_pop   (pop),
        .o_rdata (pop_job),
        .o_stat  (qstat)
    );

    lpkv_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_qstat           (qstat),
        .i_job             (pop_job),
        .o_pop             (pop),
        .o_clearing        (clearing),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_read_value      (o_read_value),
        .o_read_length     (o_read_length),
        .o_entry_count     (o_entry_count),
        .o_read_count      (o_read_count),
        .o_write_count     (o_write_count),
        .o_collision_count (o_collision_count)
    );

endmodule

// ===== test/lpkv_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// lpkv_checker
// Watches both channels of the key/value table, predicts each result from its
// own copy of the slot store and counters, and compares field by field.
// ============================================================================
module lpkv_checker
    import lpkv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_key,
    input  logic [63:0]        i_write_value,
    input  logic [3:0]         i_byte_count,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_status,
    input  logic [63:0]        i_read_value,
    input  logic [3:0]         i_read_length,
    input  logic [10:0]        i_entry_count,
    input  logic [63:0]        i_read_count,
    input  logic [63:0]        i_write_count,
    input  logic [63:0]        i_collision_count,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int PROBES = LPKV_CAPACITY / 4;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] rval;
        logic [3:0]  rlen;
        logic [10:0] entries;
        logic [63:0] reads;
        logic [63:0] writes;
        logic [63:0] misses;
    } t_answer;

    logic [31:0] tbl_key [LPKV_CAPACITY];
    logic [63:0] tbl_val [LPKV_CAPACITY];
    logic [3:0]  tbl_len [LPKV_CAPACITY];
    logic [10:0] n_entries;
    logic [63:0] n_reads, n_writes, n_misses;
    t_answer     answers_due[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = answers_due.size();

    function automatic logic [31:0] home_hash(input logic [31:0] k);
        logic [31:0] h;
        h = k;
        for (int r = 0; r < 2; r++) h = (h ^ (h >> 16)) * 32'h045d_9f3b;
        return h ^ (h >> 16);
    endfunction

    function automatic logic [63:0] low_mask(input logic [3:0] n);
        return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    // Apply one transaction to the table copy and return its answer
    function automatic t_answer table_apply(input logic [1:0] op, input logic [31:0] k,
                                            input logic [63:0] wv, input logic [3:0] c);
        t_answer a;
        int      idx;
        logic    done;
        logic [63:0] m;
        a = '0;
        a.status = ST_REJ;
        idx = home_hash(k) % LPKV_CAPACITY;
        done = 0;
        if (op == OP_SET && k != 0 && c <= VALUE_BYTES) begin
            for (int d = 0; d < PROBES && !done; d++) begin
                if (tbl_key[idx] == 0 || tbl_key[idx] == k) begin
                    m = low_mask(c);
                    if (tbl_key[idx] == 0) begin
                        tbl_key[idx] = k;
                        n_entries++;
                    end
                    tbl_len[idx] = c;
                    tbl_val[idx] = (tbl_val[idx] & ~m) | (wv & m);
                    n_writes++;
                    done = 1;
                end else begin
                    idx = (idx + 1) % LPKV_CAPACITY;
                end
            end
            if (done) a.status = ST_OK;
            else begin
                a.status = ST_FULL;
                n_misses++;
            end
        end else if (op == OP_GET && k != 0) begin
            a.status = ST_MISS;
            for (int d = 0; d < PROBES && !done; d++) begin
                if (tbl_key[idx] == k) begin
                    if (c >= tbl_len[idx]) begin
                        a.rval = tbl_val[idx] & low_mask(tbl_len[idx]);
                        a.rlen = tbl_len[idx];
                        n_reads++;
                        a.status = ST_OK;
                        done = 1;
                    end
                end else if (tbl_key[idx] == 0) begin
                    done = 1;
                end
                idx = (idx + 1) % LPKV_CAPACITY;
            end
        end else if (op == OP_ADD && k != 0) begin
            a.status = ST_FULL;
            for (int d = 0; d < PROBES && !done; d++) begin
                if (tbl_key[idx] == k) begin
                    a.rval = tbl_val[idx];
                    tbl_val[idx] = tbl_val[idx] + wv;
                    a.status = ST_OK;
                    done = 1;
                end else if (tbl_key[idx] == 0) begin
                    tbl_key[idx] = k;
                    tbl_len[idx] = 4'(VALUE_BYTES);
                    tbl_val[idx] = wv;
                    n_entries++;
                    a.status = ST_OK;
                    done = 1;
                end
                idx = (idx + 1) % LPKV_CAPACITY;
            end
        end
        a.entries = n_entries;
        a.reads   = n_reads;
        a.writes  = n_writes;
        a.misses  = n_misses;
        return a;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    // Predict on accepted input, compare on accepted output
    always @(posedge i_clk) begin
        t_answer a;
        if (!i_rst_n) begin
            for (int i = 0; i < LPKV_CAPACITY; i++) begin
                tbl_key[i] = 0;
                tbl_val[i] = 0;
                tbl_len[i] = 0;
            end
            n_entries = 0;
            n_reads = 0;
            n_writes = 0;
            n_misses = 0;
            answers_due.delete();
            fails = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, i_status);
                    fails++;
                end else begin
                    a = answers_due.pop_front();
                    check_field("status", a.status, i_status);
                    check_field("read_value", a.rval, i_read_value);
                    check_field("read_length", a.rlen, i_read_length);
                    check_field("entry_count", a.entries, i_entry_count);
                    check_field("read_count", a.reads, i_read_count);
                    check_field("write_count", a.writes, i_write_count);
                    check_field("collision_count", a.misses, i_collision_count);
                end
            end
            if (i_valid && !i_in_stall)
                answers_due.push_back(table_apply(i_opcode, i_key, i_write_value,
                                                  i_byte_count));
        end
    end

endmodule

// ===== test/tb_linear_probe_kv_table.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_linear_probe_kv_table
// Drives directed and random set/get/fetch-add and bad-opcode transactions into
// the table with random idling on both sides; a checker module predicts and compares.
// ============================================================================
module tb_linear_probe_kv_table;
    import lpkv_pkg::*;

    localparam int  LIMIT_CYCLES = 4_000_000;
    localparam int  RANDOM_ITEMS = 2000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [1:0]         opcode = OP_SET;
    logic signed [31:0] key = 0;
    logic [63:0]        wval = 0;
    logic [3:0]         bcount = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [1:0]         status;
    logic [63:0]        rval;
    logic [3:0]         rlen;
    logic [10:0]        entries;
    logic [63:0]        reads, writes, misses;
    int                 fail_count, pending;
    int                 cycle = 0;
    logic               calm = 0;
    logic [31:0]        key_pool[16];

    always #10 clk = ~clk;

    linear_probe_kv_table dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_opcode(opcode), .i_key(key), .i_write_value(wval), .i_byte_count(bcount),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(status),
        .o_read_value(rval), .o_read_length(rlen), .o_entry_count(entries),
        .o_read_count(reads), .o_write_count(writes), .o_collision_count(misses)
    );

    lpkv_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_opcode(opcode), .i_key(key), .i_write_value(wval), .i_byte_count(bcount),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_read_value(rval), .i_read_length(rlen), .i_entry_count(entries),
        .i_read_count(reads), .i_write_count(writes), .i_collision_count(misses),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 12);

    // Present one transaction, optionally after an idle gap, wait for acceptance;
    // valid stays up until the next transaction or idle cycle replaces it
    task automatic send(input logic [1:0] op, input logic [31:0] k,
                        input logic [63:0] v, input logic [3:0] c);
        while (!calm && $urandom_range(99) < 12) begin
            in_valid <= 0;
            @(negedge clk);
        end
        opcode   <= op;
        key      <= k;
        wval     <= v;
        bcount   <= c;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        int          r;
        logic [1:0]  op;
        logic [31:0] k;
        repeat (8) @(negedge clk);
        rst_n <= 1;
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom | 1;

        // Directed: extremes, every operation, rejects, partial writes, room
        send(OP_SET, 32'h8000_0000, '1, 4'd8);
        send(OP_SET, 32'h7fff_ffff, 64'h0123_4567_89ab_cdef, 4'd0);
        send(OP_GET, 32'h7fff_ffff, 0, 4'd0);
        send(OP_SET, 32'h7fff_ffff, 64'hffee_ddcc_bbaa_9988, 4'd3);
        send(OP_GET, 32'h7fff_ffff, 0, 4'd2);
        send(OP_GET, 32'h7fff_ffff, 0, 4'd15);
        send(OP_SET, 32'h7fff_ffff, 64'h1111_1111_1111_1111, 4'd8);
        send(OP_SET, 32'h7fff_ffff, 0, 4'd1);
        send(OP_GET, 32'h7fff_ffff, 0, 4'd8);
        send(OP_SET, 0, 1, 4'd4);
        send(OP_SET, 5, 1, 4'd9);
        send(OP_SET, 5, 1, 4'd15);
        send(OP_GET, 0, 0, 4'd8);
        send(OP_ADD, 0, 1, 4'd0);
        send(OP_GET, 32'hdead_beef, 0, 4'd8);
        send(OP_ADD, 32'h8000_0000, 64'd1, 4'd0);
        send(OP_GET, 32'h8000_0000, 0, 4'd8);
        send(OP_ADD, 32'h1234, '1, 4'd7);
        send(OP_ADD, 32'h1234, '1, 4'd7);
        send(OP_GET, 32'h1234, 0, 4'd7);
        send(OP_GET, 32'h1234, 0, 4'd8);
        send(OP_BAD, 32'h1234, '1, 4'd15);
        send(OP_BAD, 0, 0, 4'd0);

        // Random: mostly a small hot key set, some wide keys, rare bad ops
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 800 && n < 1100);
            r = $urandom_range(99);
            op = (r < 40) ? OP_SET : (r < 75) ? OP_GET : (r < 97) ? OP_ADD : OP_BAD;
            r = $urandom_range(99);
            k = (r < 70) ? key_pool[$urandom_range(15)] : (r < 75) ? 32'd0 : $urandom;
            send(op, k, rand64(), 4'($urandom_range(15)));
        end
        in_valid <= 0;
        calm = 0;

        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lpkv_pkg.sv
rtl/lpkv_fifo.sv
rtl/lpkv_front.sv
rtl/lpkv_back.sv
rtl/linear_probe_kv_table.sv
test/lpkv_checker.sv
test/tb_linear_probe_kv_table.sv
